// File: rtl/keypad_code_entry_macros.svh
// Assertion macros shared by the keypad code entry RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef KEYPAD_CODE_ENTRY_MACROS_SVH
`define KEYPAD_CODE_ENTRY_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold on every clock edge outside reset
`define KCE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("kce assertion failed");
// Implication checked in the same cycle
`define KCE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kce implication failed");
// Implication checked in the next cycle
`define KCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kce next-cycle implication failed");
`else
`define KCE_ASSERT(lbl, clk, rst, prop)
`define KCE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define KCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/kce_pkg.sv
// Types, constants and helpers for the keypad code entry block.
// No dependencies; imported by every module of the block.
package kce_pkg;

  // Number of digits in a complete code
  localparam int unsigned CODE_DIGITS = 4;

  // Elaboration-time power of ten
  function automatic longint unsigned pow10(input int unsigned n);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint unsigned PLACE_MAX = pow10(CODE_DIGITS);
  localparam int unsigned     ACC_W     = $clog2(PLACE_MAX + 1);
  localparam int unsigned     DIG_W     = $clog2(CODE_DIGITS + 1);
  localparam int unsigned     FIELD_W   = 14;
  localparam int unsigned     KEY_W     = 8;
  localparam int unsigned     TIMER_W   = 32;
  localparam int unsigned     CFG_IDX_W = 1;
  localparam int unsigned     CFG_DATA_W = 32;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(200000);
  localparam logic [KEY_W-1:0]   ENTER_RESET   = KEY_W'(10);
  localparam logic [KEY_W-1:0]   MAX_DIGIT_KEY = KEY_W'(9);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SCAN = 2'd1,
    OP_POLL = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_BUSY    = 2'd0,
    ST_READY   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT_TICKS = 1'd0,
    CFG_ENTER_KEY     = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] code_out;
    logic               display_write;
    logic [FIELD_W-1:0] display_value;
  } result_t;

  typedef struct packed {
    logic [TIMER_W-1:0] timeout_ticks;
    logic [KEY_W-1:0]   enter_key_code;
  } cfg_t;

  // Low field bits of an accumulator value, zero-extended when narrower
  function automatic logic [FIELD_W-1:0] to_field(input logic [ACC_W-1:0] v);
    logic [ACC_W+FIELD_W-1:0] wide;
    wide = {{FIELD_W{1'b0}}, v};
    return wide[FIELD_W-1:0];
  endfunction

endpackage

// File: rtl/kce_entry_core.sv
// Entry state and combinational item processing for keypad code entry.
// Depends on kce_pkg and keypad_code_entry_macros.svh.
`include "keypad_code_entry_macros.svh"

module kce_entry_core
  import kce_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic               capture_enabled, capture_enabled_next;
  logic               fresh_start, fresh_start_next;
  logic [DIG_W-1:0]   digits_entered, digits_entered_next;
  logic [ACC_W-1:0]   code_accum, code_accum_next;
  logic [ACC_W-1:0]   place_value, place_value_next;
  logic [TIMER_W-1:0] entry_timer, entry_timer_next;
  status_t            entry_status, entry_status_next;
  logic               status_taken, status_taken_next;
  logic               awaiting_first_poll, awaiting_first_poll_next;

  // Values after the start-of-entry reload on a scan
  logic [DIG_W-1:0]   dig_f;
  logic [ACC_W-1:0]   acc_f;
  logic [ACC_W-1:0]   pv_f;
  logic [TIMER_W-1:0] timer_f;
  logic [ACC_W-1:0]   digit_term;
  logic [ACC_W+3:0]   product;
  logic [ACC_W-1:0]   acc_sum;
  status_t            poll_status;

  // Start-of-entry view and the digit arithmetic
  always_comb begin
    dig_f      = fresh_start ? '0 : digits_entered;
    acc_f      = fresh_start ? '0 : code_accum;
    pv_f       = fresh_start ? ACC_W'(1) : place_value;
    timer_f    = fresh_start ? cfg.timeout_ticks : entry_timer;
    product    = item.key[3:0] * pv_f;
    digit_term = product[ACC_W-1:0];
    acc_sum    = acc_f + digit_term;
  end

  // Next state and result for one item
  always_comb begin
    capture_enabled_next     = capture_enabled;
    fresh_start_next         = fresh_start;
    digits_entered_next      = digits_entered;
    code_accum_next          = code_accum;
    place_value_next         = place_value;
    entry_timer_next         = entry_timer;
    entry_status_next        = entry_status;
    status_taken_next        = status_taken;
    awaiting_first_poll_next = awaiting_first_poll;
    poll_status              = awaiting_first_poll ? ST_BUSY : entry_status;
    result                   = '0;
    result.status            = entry_status;

    unique case (item.op)
      OP_TICK: begin
        if (entry_timer != '0) begin
          entry_timer_next = entry_timer - TIMER_W'(1);
        end
      end
      OP_SCAN: begin
        if (status_taken) begin
          status_taken_next = 1'b0;
          entry_status_next = ST_BUSY;
          if (capture_enabled) begin
            fresh_start_next    = 1'b0;
            digits_entered_next = dig_f;
            code_accum_next     = acc_f;
            place_value_next    = pv_f;
            entry_timer_next    = timer_f;
            priority if (timer_f == '0) begin
              // expired entry: clear and report timeout
              code_accum_next       = '0;
              digits_entered_next   = '0;
              place_value_next      = ACC_W'(1);
              entry_status_next     = ST_TIMEOUT;
              fresh_start_next      = 1'b1;
              capture_enabled_next  = 1'b0;
              result.display_write  = 1'b1;
            end else if (item.key == cfg.enter_key_code &&
                         dig_f == DIG_W'(CODE_DIGITS)) begin
              entry_status_next     = ST_READY;
              capture_enabled_next  = 1'b0;
              fresh_start_next      = 1'b1;
              result.display_write  = 1'b1;
            end else if (item.key > MAX_DIGIT_KEY ||
                         dig_f >= DIG_W'(CODE_DIGITS)) begin
              // drop the key
            end else begin
              code_accum_next      = acc_sum;
              digits_entered_next  = dig_f + DIG_W'(1);
              place_value_next     = (pv_f << 3) + (pv_f << 1);
              result.display_write = 1'b1;
              result.display_value = to_field(acc_sum);
            end
          end
        end
        result.status = entry_status_next;
      end
      OP_POLL: begin
        if (awaiting_first_poll) begin
          capture_enabled_next = 1'b1;
        end
        awaiting_first_poll_next = (poll_status == ST_READY ||
                                    poll_status == ST_TIMEOUT);
        if (poll_status == ST_READY) begin
          result.code_out = to_field(code_accum);
        end
        entry_status_next = ST_BUSY;
        status_taken_next = 1'b1;
        result.status     = poll_status;
      end
      default: begin
        // unused kind: report status only
      end
    endcase
  end

  // Hold entry state; advance only when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_enabled     <= 1'b0;
      fresh_start         <= 1'b1;
      digits_entered      <= '0;
      code_accum          <= '0;
      place_value         <= ACC_W'(1);
      entry_timer         <= '0;
      entry_status        <= ST_BUSY;
      status_taken        <= 1'b1;
      awaiting_first_poll <= 1'b1;
    end else if (fire) begin
      capture_enabled     <= capture_enabled_next;
      fresh_start         <= fresh_start_next;
      digits_entered      <= digits_entered_next;
      code_accum          <= code_accum_next;
      place_value         <= place_value_next;
      entry_timer         <= entry_timer_next;
      entry_status        <= entry_status_next;
      status_taken        <= status_taken_next;
      awaiting_first_poll <= awaiting_first_poll_next;
    end
  end

  `KCE_ASSERT(a_digits_capped, clk, rst, digits_entered <= DIG_W'(CODE_DIGITS))
  `KCE_ASSERT_IMP(a_place_at_start, clk, rst, digits_entered == '0, place_value == ACC_W'(1))
  `KCE_ASSERT_IMP(a_disarmed_is_fresh, clk, rst, !capture_enabled, fresh_start)
  `KCE_ASSERT_NEXT(a_poll_busy, clk, rst, fire && item.op == OP_POLL, entry_status == ST_BUSY)

endmodule

// File: rtl/keypad_code_entry.sv
// Keypad code entry: input register, entry core and result register.
// Depends on kce_pkg, kce_entry_core and keypad_code_entry_macros.svh.
//
// Usage:
//   in_item carries one item per handshake (op: tick, scan or poll; key).
//   An item is taken at a clock edge with in_valid high and in_stall low.
//   Every item yields exactly one result on out_item, handed over at an
//   edge with out_valid high and out_stall low.
//   An accepted item sits in the input register, then passes through the entry
//   logic into the result register once that register is free or moving on.
//   Throughput is one item per cycle while the receiver does not stall: the
//   entry state is updated by combinational logic between the two registers.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; in_stall rises only once both are occupied.
//   Configuration (timeout ticks at index 0, enter key code at index 1) is
//   taken on cfg_valid; cfg_ready is always high. Write it while idle.
//   A synchronous rst empties both registers, restores the reset entry
//   state and reloads the configuration defaults.
`include "keypad_code_entry_macros.svh"

module keypad_code_entry
  import kce_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  item_t                 in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_item_q;
  cfg_t    cfg;
  logic    advance;
  logic    fire;
  result_t result;

  assign advance   = !out_valid_q || !out_stall;
  assign fire      = in_valid_q && advance;
  assign in_stall  = in_valid_q && !advance;
  assign out_valid = out_valid_q;
  assign out_item  = out_item_q;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks  <= TIMEOUT_RESET;
      cfg.enter_key_code <= ENTER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks  <= cfg_data[TIMER_W-1:0];
        CFG_ENTER_KEY:     cfg.enter_key_code <= cfg_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: load when empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_q <= in_item;
    end
  end

  kce_entry_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item_q),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  `KCE_ASSERT_NEXT(a_fire_fills_out, clk, rst, fire, out_valid)
  `KCE_ASSERT_IMP(a_stall_only_full, clk, rst, in_stall, out_valid_q && in_valid_q)
  `KCE_ASSERT_NEXT(a_held_result, clk, rst, out_valid && out_stall, $stable(out_item_q))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for keypad_code_entry: random bursts of ticks, scans and polls
// against an in-bench entry predictor, with configuration phases in between.
// Depends on kce_pkg and the keypad_code_entry RTL.
`timescale 1ns / 1ps

module tb_top;
  import kce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  item_t                 in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  result_t               out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  keypad_code_entry dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Predicted registers and entry state
  logic [TIMER_W-1:0] cfg_timeout = TIMEOUT_RESET;
  logic [KEY_W-1:0]   cfg_enter   = ENTER_RESET;
  bit                 capture_on   = 1'b0;
  bit                 new_entry    = 1'b1;
  int unsigned        digit_count  = 0;
  logic [31:0]        code_sum     = '0;
  logic [31:0]        place        = 32'd1;
  logic [TIMER_W-1:0] entry_timer  = '0;
  status_t            entry_state  = ST_BUSY;
  bit                 state_polled = 1'b1;
  bit                 first_poll   = 1'b1;

  item_t       keypad_items[$];
  result_t     due_results[$];
  int unsigned items_queued = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  // Sender and receiver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;
  result_t     want;

  // Advance the predicted entry state by one item and return its result
  function automatic result_t keypad_step(input item_t it);
    result_t r;
    r = '0;
    case (it.op)
      OP_TICK: begin
        if (entry_timer != 0) entry_timer = entry_timer - 1;
        r.status = entry_state;
      end
      OP_SCAN: begin
        if (state_polled) begin
          state_polled = 1'b0;
          if (!capture_on) begin
            entry_state = ST_BUSY;
          end else begin
            if (new_entry) begin
              code_sum    = '0;
              digit_count = 0;
              place       = 32'd1;
              entry_state = ST_BUSY;
              entry_timer = cfg_timeout;
              new_entry   = 1'b0;
            end
            if (entry_timer == 0) begin
              // expired entry: clear and report timeout
              code_sum    = '0;
              digit_count = 0;
              place       = 32'd1;
              entry_state = ST_TIMEOUT;
              new_entry   = 1'b1;
              capture_on  = 1'b0;
              r.display_write = 1'b1;
            end else if (it.key == cfg_enter && digit_count == CODE_DIGITS) begin
              entry_state = ST_READY;
              capture_on  = 1'b0;
              new_entry   = 1'b1;
              r.display_write = 1'b1;
            end else if (it.key > MAX_DIGIT_KEY || digit_count >= CODE_DIGITS) begin
              entry_state = ST_BUSY;
            end else begin
              // first key is the units digit
              code_sum = code_sum + it.key * place;
              r.display_write = 1'b1;
              r.display_value = code_sum[FIELD_W-1:0];
              digit_count = digit_count + 1;
              place = place * 10;
              entry_state = ST_BUSY;
            end
          end
        end
        r.status = entry_state;
      end
      OP_POLL: begin
        if (first_poll) begin
          capture_on  = 1'b1;
          first_poll  = 1'b0;
          entry_state = ST_BUSY;
        end
        r.status = entry_state;
        if (entry_state == ST_READY) begin
          r.code_out = code_sum[FIELD_W-1:0];
          first_poll = 1'b1;
        end else if (entry_state == ST_TIMEOUT) begin
          first_poll = 1'b1;
        end
        if (entry_state == ST_READY || entry_state == ST_TIMEOUT) entry_state = ST_BUSY;
        state_polled = 1'b1;
      end
      default: begin
        r.status = entry_state;
      end
    endcase
    return r;
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [KEY_W-1:0] key);
    keypad_items.push_back(item_t'({op, key}));
    items_queued++;
  endtask

  // Pick a key: mostly digits, some enter keys, some arbitrary codes
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return KEY_W'($urandom_range(0, 9));
    if (r < 85) return cfg_enter;
    return KEY_W'($urandom_range(0, 255));
  endfunction

  // Queue one entry attempt: arm, keys with polls and ticks, enter, poll
  task automatic add_session();
    int unsigned steps;
    int unsigned ticks;
    int unsigned r;
    steps = $urandom_range(3, 7);
    push_item(OP_POLL, KEY_W'($urandom_range(0, 255)));
    for (int unsigned s = 0; s < steps; s++) begin
      r = $urandom_range(0, 99);
      if (r < 60) ticks = 0;
      else if (r < 90) ticks = $urandom_range(1, 3);
      else ticks = $urandom_range(4, 12);
      for (int unsigned t = 0; t < ticks; t++) push_item(OP_TICK, KEY_W'($urandom_range(0, 255)));
      push_item(OP_SCAN, pick_key());
      // drop in a scan that lands before the poll
      if ($urandom_range(0, 9) == 0) push_item(OP_SCAN, pick_key());
      // skip a poll now and then
      if ($urandom_range(0, 14) != 0) push_item(OP_POLL, KEY_W'($urandom_range(0, 255)));
    end
    push_item(OP_SCAN, cfg_enter);
    push_item(OP_POLL, KEY_W'($urandom_range(0, 255)));
    // noise between sessions
    if ($urandom_range(0, 9) == 0) begin
      r = $urandom_range(1, 3);
      for (int unsigned n = 0; n < r; n++) begin
        push_item(2'($urandom_range(0, 2)), KEY_W'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic add_sessions(input int unsigned count);
    int unsigned start;
    start = items_queued;
    while (items_queued - start < count) add_session();
  endtask

  // Hold until every queued item is sent and every result is back
  task automatic wait_drained();
    do @(posedge clk);
    while (keypad_items.size() != 0 || in_valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_TIMEOUT_TICKS) cfg_timeout = data;
    else cfg_enter = data[KEY_W-1:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stimulus and phases
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings
    push_item(OP_SCAN, 8'd5);     // capture not armed
    push_item(OP_SCAN, 8'd7);     // status not yet polled
    push_item(OP_TICK, 8'd0);
    push_item(OP_POLL, 8'd0);     // arm capture
    push_item(OP_SCAN, 8'd10);    // enter before full length
    push_item(OP_POLL, 8'hff);
    push_item(OP_SCAN, 8'd9);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd0);
    push_item(OP_TICK, 8'hff);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd9);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd9);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd3);     // past full length
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd200);   // invalid key
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd10);    // confirm
    push_item(OP_POLL, 8'd0);     // ready with code
    push_item(2'b11, 8'hff);      // unused op
    push_item(OP_POLL, 8'd0);
    push_item(OP_TICK, 8'd0);
    wait_drained();

    // short timer, default enter
    write_reg(CFG_TIMEOUT_TICKS, 32'd3);
    add_sessions(280);
    wait_drained();

    // extremes: longest timer, highest enter code
    write_reg(CFG_TIMEOUT_TICKS, 32'hffff_ffff);
    write_reg(CFG_ENTER_KEY, 32'd255);
    add_sessions(260);
    wait_drained();

    // shortest nonzero timer
    write_reg(CFG_TIMEOUT_TICKS, 32'd1);
    write_reg(CFG_ENTER_KEY, 32'd200);
    add_sessions(220);
    wait_drained();

    // zero timer and enter code below ten
    write_reg(CFG_TIMEOUT_TICKS, 32'd0);
    write_reg(CFG_ENTER_KEY, 32'd5);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd1);
    push_item(OP_POLL, 8'd0);
    push_item(OP_POLL, 8'd0);
    push_item(OP_SCAN, 8'd5);
    push_item(OP_TICK, 8'd0);
    push_item(OP_POLL, 8'd0);
    add_sessions(30);
    wait_drained();

    write_reg(CFG_TIMEOUT_TICKS, 32'd40);
    add_sessions(160);
    wait_drained();

    // random settings
    for (int p = 0; p < 2; p++) begin
      write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'($urandom_range(2, 30)));
      write_reg(CFG_ENTER_KEY, CFG_DATA_W'($urandom_range(10, 255)));
      add_sessions(160);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: send queued items in bursts, predict each accepted item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) due_results.push_back(keypad_step(in_item));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (keypad_items.size() > 0) begin
          in_valid <= 1'b1;
          in_item  <= keypad_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with nothing due: %p", out_item);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.code_out !== want.code_out) begin
            $error("code_out: expected %0d, got %0d", want.code_out, out_item.code_out);
            errors++;
          end
          if (out_item.display_write !== want.display_write) begin
            $error("display_write: expected %0d, got %0d", want.display_write,
                   out_item.display_write);
            errors++;
          end
          if (out_item.display_value !== want.display_value) begin
            $error("display_value: expected %0d, got %0d", want.display_value,
                   out_item.display_value);
            errors++;
          end
        end
      end
      // stall modes: none, light random, heavy random
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(10, 60);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
